// File: design/esn_pkg.sv
// Shared types and constants for the eventual-safe-node finder.
package esn_pkg;

	// fixed field widths
	localparam int NODE_W = 6;
	localparam int CNT_W  = 7;

	// defaults for the top-level parameters and the node count register
	localparam int                MAX_NODES_DEF  = 64;
	localparam int                MAX_EDGES_DEF  = 256;
	localparam logic [CNT_W-1:0]  NODE_COUNT_RST = 7'd64;

	// sequencer states
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLEAR,
		ST_CNT_RD,
		ST_CNT_DEG,
		ST_CNT_WR,
		ST_SEED_RD,
		ST_SEED_CHK,
		ST_POP_RD,
		ST_POP_CHK,
		ST_PEEL_RD,
		ST_PEEL_DEG,
		ST_PEEL_WR,
		ST_EMIT
	} esn_state_t;

	// degree unit operations
	typedef enum logic {
		ALU_INC,
		ALU_DEC
	} esn_alu_op_t;

	// degree unit status
	typedef struct packed {
		logic a_zero;
		logic res_zero;
	} esn_alu_flags_t;

	// one result word from the sequencer to the output register
	typedef struct packed {
		logic              valid;
		logic [NODE_W-1:0] node_index;
		logic              node_valid;
		logic              edge_overflow;
		logic              last;
	} esn_emit_t;

endpackage

// File: design/esn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module esn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// File: design/esn_alu.sv
// Shared degree unit: increment or decrement a pending out-degree, zero tests.
module esn_alu import esn_pkg::*; #(
	parameter int WIDTH = 9
) (
	input  esn_alu_op_t      op,
	input  logic [WIDTH-1:0] a,
	output logic [WIDTH-1:0] res,
	output esn_alu_flags_t   flags
);

	// add or subtract one
	always_comb begin
		case (op)
			ALU_INC: res = a + 1'b1;
			ALU_DEC: res = a - 1'b1;
			default: res = a;
		endcase
	end

	assign flags.a_zero   = (a == '0);
	assign flags.res_zero = (res == '0);

endmodule

// File: design/esn_seq.sv
// Sequencer: edge load, degree count, Kahn peeling and ordered result scan.
module esn_seq import esn_pkg::*; #(
	parameter int  MAX_NODES = MAX_NODES_DEF,
	parameter int  MAX_EDGES = MAX_EDGES_DEF,
	localparam int IDX_W     = $clog2(MAX_NODES),
	localparam int NCW       = $clog2(MAX_NODES + 1),
	localparam int EA        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
	localparam int EW        = $clog2(MAX_EDGES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CNT_W-1:0]    node_count,
	// input words
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [NODE_W-1:0]   in_from,
	input  logic [NODE_W-1:0]   in_to,
	input  logic                in_present,
	input  logic                in_last,
	// result words
	input  logic                out_free,
	output esn_emit_t           emit,
	// edge store
	output logic                edge_we,
	output logic [EA-1:0]       edge_waddr,
	output logic [2*NODE_W-1:0] edge_wdata,
	output logic [EA-1:0]       edge_raddr,
	input  logic [2*NODE_W-1:0] edge_rdata,
	// pending out-degree store
	output logic                deg_we,
	output logic [IDX_W-1:0]    deg_waddr,
	output logic [EW-1:0]       deg_wdata,
	output logic [IDX_W-1:0]    deg_raddr,
	input  logic [EW-1:0]       deg_rdata,
	// ready queue
	output logic                q_we,
	output logic [IDX_W-1:0]    q_waddr,
	output logic [NODE_W-1:0]   q_wdata,
	output logic [IDX_W-1:0]    q_raddr,
	input  logic [NODE_W-1:0]   q_rdata,
	// degree unit
	output esn_alu_op_t         alu_op,
	output logic [EW-1:0]       alu_a,
	input  logic [EW-1:0]       alu_res,
	input  esn_alu_flags_t      alu_flags
);

	esn_state_t state_q, state_d;

	logic [EW-1:0]        edges_q;
	logic [EW-1:0]        e_q;
	logic                 ovf_q;
	logic [NCW-1:0]       v_q;
	logic [NCW-1:0]       head_q;
	logic [NCW-1:0]       tail_q;
	logic [MAX_NODES-1:0] mark_q;
	logic [NODE_W-1:0]    node_q;
	logic [NODE_W-1:0]    src_q;
	logic [NODE_W-1:0]    held_q;
	logic                 have_held_q;

	logic [NCW-1:0]    n_w;
	logic [CNT_W-1:0]  n_cmp;
	logic              in_ok;
	logic              edge_room;
	logic [NODE_W-1:0] e_src;
	logic [NODE_W-1:0] e_dst;
	logic              e_ok;
	logic              e_hit;
	logic              e_end;
	logic              v_end;
	logic              clr_end;
	logic              q_empty;
	logic              q_room;
	logic              pop_ok;
	logic              mark_v;

	// active node count, saturated to capacity
	assign n_w   = (node_count > CNT_W'(MAX_NODES)) ? NCW'(MAX_NODES) : node_count[NCW-1:0];
	assign n_cmp = CNT_W'(n_w);

	assign in_ok     = in_present && (CNT_W'(in_from) < n_cmp) && (CNT_W'(in_to) < n_cmp);
	assign edge_room = (edges_q < EW'(MAX_EDGES));

	// stored edge fields: source low, target high
	assign e_src = edge_rdata[NODE_W-1:0];
	assign e_dst = edge_rdata[2*NODE_W-1:NODE_W];
	assign e_ok  = (CNT_W'(e_src) < n_cmp) && (CNT_W'(e_dst) < n_cmp);
	assign e_hit = e_ok && (e_dst == node_q);
	assign e_end = (e_q == edges_q);

	assign v_end   = (v_q == n_w);
	assign clr_end = (v_q == NCW'(MAX_NODES - 1));
	assign q_empty = (head_q == tail_q);
	assign q_room  = (tail_q < NCW'(MAX_NODES));
	assign pop_ok  = (CNT_W'(q_rdata) < n_cmp);
	assign mark_v  = mark_q[v_q[IDX_W-1:0]];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:     if (in_valid && in_last) state_d = ST_CLEAR;
			ST_CLEAR:    if (clr_end) state_d = ST_CNT_RD;
			ST_CNT_RD:   state_d = e_end ? ST_SEED_RD : ST_CNT_DEG;
			ST_CNT_DEG:  state_d = e_ok ? ST_CNT_WR : ST_CNT_RD;
			ST_CNT_WR:   state_d = ST_CNT_RD;
			ST_SEED_RD:  state_d = v_end ? ST_POP_RD : ST_SEED_CHK;
			ST_SEED_CHK: state_d = ST_SEED_RD;
			ST_POP_RD:   state_d = q_empty ? ST_EMIT : ST_POP_CHK;
			ST_POP_CHK:  state_d = pop_ok ? ST_PEEL_RD : ST_POP_RD;
			ST_PEEL_RD:  state_d = e_end ? ST_POP_RD : ST_PEEL_DEG;
			ST_PEEL_DEG: state_d = e_hit ? ST_PEEL_WR : ST_PEEL_RD;
			ST_PEEL_WR:  state_d = ST_PEEL_RD;
			ST_EMIT:     if (out_free && v_end) state_d = ST_LOAD;
			default:     state_d = ST_LOAD;
		endcase
	end

	// memory ports, degree unit and result word
	always_comb begin
		in_ready   = 1'b0;
		edge_we    = 1'b0;
		edge_waddr = edges_q[EA-1:0];
		edge_wdata = {in_to, in_from};
		edge_raddr = e_q[EA-1:0];
		deg_we     = 1'b0;
		deg_waddr  = src_q[IDX_W-1:0];
		deg_wdata  = alu_res;
		deg_raddr  = e_src[IDX_W-1:0];
		q_we       = 1'b0;
		q_waddr    = tail_q[IDX_W-1:0];
		q_wdata    = src_q;
		q_raddr    = head_q[IDX_W-1:0];
		alu_op     = ALU_INC;
		alu_a      = deg_rdata;
		emit       = '0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				edge_we  = in_valid && in_ok && edge_room;
			end
			ST_CLEAR: begin
				deg_we    = 1'b1;
				deg_waddr = v_q[IDX_W-1:0];
				deg_wdata = '0;
			end
			ST_CNT_WR: begin
				alu_op = ALU_INC;
				deg_we = 1'b1;
			end
			ST_SEED_RD: begin
				deg_raddr = v_q[IDX_W-1:0];
			end
			ST_SEED_CHK: begin
				// nodes with no outgoing edge start the peel
				q_we    = alu_flags.a_zero && q_room;
				q_wdata = NODE_W'(v_q);
			end
			ST_PEEL_WR: begin
				alu_op = ALU_DEC;
				deg_we = !alu_flags.a_zero;
				q_we   = !alu_flags.a_zero && alu_flags.res_zero && q_room;
			end
			ST_EMIT: begin
				// hold one marked node back so the final one carries last
				emit.edge_overflow = ovf_q;
				if (out_free) begin
					if (v_end) begin
						emit.valid      = 1'b1;
						emit.node_index = have_held_q ? held_q : '0;
						emit.node_valid = have_held_q;
						emit.last       = 1'b1;
					end else if (mark_v && have_held_q) begin
						emit.valid      = 1'b1;
						emit.node_index = held_q;
						emit.node_valid = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// state, counters and marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			edges_q     <= '0;
			e_q         <= '0;
			ovf_q       <= 1'b0;
			v_q         <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			mark_q      <= '0;
			node_q      <= '0;
			src_q       <= '0;
			held_q      <= '0;
			have_held_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (edge_we) begin
				edges_q <= edges_q + 1'b1;
			end
			if (q_we) begin
				tail_q <= tail_q + 1'b1;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_valid && in_ok && !edge_room) begin
						ovf_q <= 1'b1;
					end
					if (in_valid && in_last) begin
						v_q <= '0;
					end
				end
				ST_CLEAR: begin
					v_q <= v_q + 1'b1;
					if (clr_end) begin
						e_q <= '0;
					end
				end
				ST_CNT_RD: begin
					if (e_end) begin
						v_q <= '0;
					end
				end
				ST_CNT_DEG: begin
					src_q <= e_src;
					if (!e_ok) begin
						e_q <= e_q + 1'b1;
					end
				end
				ST_CNT_WR: begin
					e_q <= e_q + 1'b1;
				end
				ST_SEED_CHK: begin
					v_q <= v_q + 1'b1;
				end
				ST_POP_RD: begin
					if (q_empty) begin
						v_q         <= '0;
						have_held_q <= 1'b0;
					end else begin
						head_q <= head_q + 1'b1;
					end
				end
				ST_POP_CHK: begin
					if (pop_ok) begin
						mark_q[q_rdata[IDX_W-1:0]] <= 1'b1;
						node_q                     <= q_rdata;
						e_q                        <= '0;
					end
				end
				ST_PEEL_DEG: begin
					src_q <= e_src;
					if (!e_hit) begin
						e_q <= e_q + 1'b1;
					end
				end
				ST_PEEL_WR: begin
					e_q <= e_q + 1'b1;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (v_end) begin
							// run done: ready for the next graph
							edges_q <= '0;
							ovf_q   <= 1'b0;
							head_q  <= '0;
							tail_q  <= '0;
							mark_q  <= '0;
						end else begin
							if (mark_v) begin
								held_q      <= NODE_W'(v_q);
								have_held_q <= 1'b1;
							end
							v_q <= v_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// queue pointers stay ordered and within the queue
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= tail_q) && (tail_q <= NCW'(MAX_NODES)))
		else $error("ready queue pointers out of order");

	// edge count never passes capacity
	a_edge_cap: assert property (@(posedge clk) disable iff (!arst_n)
		edges_q <= EW'(MAX_EDGES))
		else $error("edge count beyond capacity");

	// no result word while loading
	a_no_emit_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> !emit.valid)
		else $error("result emitted during load");

	// final word ends the run and empties the run state
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && emit.last) |=> (state_q == ST_LOAD) && (edges_q == '0)
		&& (mark_q == '0) && (tail_q == '0))
		else $error("run state not cleared after final word");

	// a decrement only happens on a nonzero degree
	a_dec_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(deg_we && (state_q == ST_PEEL_WR)) |-> (deg_rdata != '0))
		else $error("degree decremented below zero");
`endif

endmodule

// File: design/eventual_safe_nodes.sv
// Eventual safe node finder: edge stream in, safe node indices out in order.
//
// Usage: edges arrive on the s_axis channel, one word per cycle while
// s_axis_tready is high. tuser marks a word that carries an edge; tlast marks
// the final word of the graph. Edges naming a node at or above node_count are
// ignored; edges beyond MAX_EDGES are dropped and reported in edge_overflow.
// After the last word the block stops taking input and works the graph: it
// clears all MAX_NODES entries of the degree store, counts out-degrees over
// the stored edges, seeds the queue with the nodes of zero out-degree, then
// for each queued node peels the stored edges that point at it, until it
// finds the queue empty. Safe nodes then leave on m_axis in ascending order,
// one word per cycle at most, tlast on the final one; if none is safe one
// word with node_valid clear is sent. A stalled m_axis holds the word in the
// output register and pauses the scan. After the final word the block takes
// a new graph at once. Reset sets node_count to 64 and empties the run state;
// node_count is written through cfg_wr_en / cfg_wr_data.
module eventual_safe_nodes import esn_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int MAX_EDGES = MAX_EDGES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,     // node_count
	// edge words
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [15:0]      s_axis_tdata,    // from_node[5:0], to_node[11:6], zero
	input  logic             s_axis_tuser,    // edge_present
	input  logic             s_axis_tlast,    // last_item
	// result words
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,    // node_index[5:0], zero
	output logic [1:0]       m_axis_tuser,    // node_valid[0], edge_overflow[1]
	output logic             m_axis_tlast     // last_result
);

	localparam int IDX_W = $clog2(MAX_NODES);
	localparam int EA    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EW    = $clog2(MAX_EDGES + 1);

	logic [CNT_W-1:0] node_count_q;
	logic             out_valid_q;
	esn_emit_t        out_q;
	logic             out_free;
	esn_emit_t        emit;

	logic                edge_we;
	logic [EA-1:0]       edge_waddr;
	logic [2*NODE_W-1:0] edge_wdata;
	logic [EA-1:0]       edge_raddr;
	logic [2*NODE_W-1:0] edge_rdata;
	logic                deg_we;
	logic [IDX_W-1:0]    deg_waddr;
	logic [EW-1:0]       deg_wdata;
	logic [IDX_W-1:0]    deg_raddr;
	logic [EW-1:0]       deg_rdata;
	logic                q_we;
	logic [IDX_W-1:0]    q_waddr;
	logic [NODE_W-1:0]   q_wdata;
	logic [IDX_W-1:0]    q_raddr;
	logic [NODE_W-1:0]   q_rdata;
	esn_alu_op_t         alu_op;
	logic [EW-1:0]       alu_a;
	logic [EW-1:0]       alu_res;
	esn_alu_flags_t      alu_flags;

	// node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_wr_en) begin
			node_count_q <= cfg_wr_data;
		end
	end

	// output register
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
			out_q       <= emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q.node_index};
	assign m_axis_tuser  = {out_q.edge_overflow, out_q.node_valid};
	assign m_axis_tlast  = out_q.last;

	esn_seq #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_count (node_count_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_from    (s_axis_tdata[5:0]),
		.in_to      (s_axis_tdata[11:6]),
		.in_present (s_axis_tuser),
		.in_last    (s_axis_tlast),
		.out_free   (out_free),
		.emit       (emit),
		.edge_we    (edge_we),
		.edge_waddr (edge_waddr),
		.edge_wdata (edge_wdata),
		.edge_raddr (edge_raddr),
		.edge_rdata (edge_rdata),
		.deg_we     (deg_we),
		.deg_waddr  (deg_waddr),
		.deg_wdata  (deg_wdata),
		.deg_raddr  (deg_raddr),
		.deg_rdata  (deg_rdata),
		.q_we       (q_we),
		.q_waddr    (q_waddr),
		.q_wdata    (q_wdata),
		.q_raddr    (q_raddr),
		.q_rdata    (q_rdata),
		.alu_op     (alu_op),
		.alu_a      (alu_a),
		.alu_res    (alu_res),
		.alu_flags  (alu_flags)
	);

	esn_alu #(
		.WIDTH (EW)
	) u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.res   (alu_res),
		.flags (alu_flags)
	);

	// edge store: target in the high half, source in the low half
	esn_ram #(
		.WIDTH (2 * NODE_W),
		.DEPTH (MAX_EDGES)
	) u_edge_ram (
		.clk     (clk),
		.wr_en   (edge_we),
		.wr_addr (edge_waddr),
		.wr_data (edge_wdata),
		.rd_addr (edge_raddr),
		.rd_data (edge_rdata)
	);

	esn_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_NODES)
	) u_deg_ram (
		.clk     (clk),
		.wr_en   (deg_we),
		.wr_addr (deg_waddr),
		.wr_data (deg_wdata),
		.rd_addr (deg_raddr),
		.rd_data (deg_rdata)
	);

	esn_ram #(
		.WIDTH (NODE_W),
		.DEPTH (MAX_NODES)
	) u_queue_ram (
		.clk     (clk),
		.wr_en   (q_we),
		.wr_addr (q_waddr),
		.wr_data (q_wdata),
		.rd_addr (q_raddr),
		.rd_data (q_rdata)
	);

endmodule
